@@ rtl/core/pwts_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic work timer scheduler: shared package
// Slot count, command codes, queued operation codes and the queue entry type
// shared by the front end, the command queue and the slot engine.
// ----------------------------------------------------------------------------
package pwts_pkg;

  // Number of work slots; the slot fields on the ports are four bits wide.
  localparam int SLOTS = 16;

  // Command codes on the input port.
  typedef enum logic [2:0] {
    CMD_POST         = 3'd0,
    CMD_POST_DELAYED = 3'd1,
    CMD_CANCEL       = 3'd2,
    CMD_ITERATE      = 3'd3,
    CMD_TIME_WRAPPED = 3'd4
  } cmd_e;

  // Operations after classification in the front end.
  typedef enum logic [1:0] {
    OP_ARM     = 2'd0,
    OP_CANCEL  = 2'd1,
    OP_ITERATE = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  // Result kinds.
  localparam logic KIND_FIRED   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // One queued operation. The value is the period for an arm and the
  // present time for an iterate.
  typedef struct packed {
    op_e         op;
    logic [3:0]  slot;
    logic [31:0] value;
  } entry_t;

endpackage : pwts_pkg

@@ rtl/core/pwts_front.sv @@
// ----------------------------------------------------------------------------
// Periodic work timer scheduler: front end
// Accepts commands, drops codes that mean nothing and slot indexes out of
// range, and turns the rest into queue entries.
// ----------------------------------------------------------------------------
module pwts_front (
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        cmd_i,
  input  logic [3:0]        slot_i,
  input  logic [31:0]       delay_i,
  input  logic [31:0]       current_time_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output pwts_pkg::entry_t  q_entry_o
);
  import pwts_pkg::*;

  localparam logic [6:0] SlotLimit = 7'(SLOTS);

  logic in_range;
  logic keep;

  // The queue being full is the only reason to hold commands off.
  assign busy     = q_full_i;
  assign in_range = ({3'b000, slot_i} < SlotLimit);

  // Classify the command.
  always_comb begin
    keep            = 1'b0;
    q_entry_o.op    = OP_ARM;
    q_entry_o.slot  = slot_i;
    q_entry_o.value = '0;
    unique case (cmd_i) inside
      CMD_POST, CMD_POST_DELAYED: begin
        keep            = in_range;
        q_entry_o.op    = OP_ARM;
        q_entry_o.value = (cmd_i == CMD_POST_DELAYED) ? delay_i : 32'd0;
      end
      CMD_CANCEL: begin
        keep         = in_range;
        q_entry_o.op = OP_CANCEL;
      end
      CMD_ITERATE: begin
        keep            = 1'b1;
        q_entry_o.op    = OP_ITERATE;
        q_entry_o.value = current_time_i;
      end
      CMD_TIME_WRAPPED: begin
        keep         = 1'b1;
        q_entry_o.op = OP_RELEASE;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push_o = start & ~busy & keep;

endmodule : pwts_front

@@ rtl/core/pwts_queue.sv @@
// ----------------------------------------------------------------------------
// Periodic work timer scheduler: command queue
// Two-entry queue that lets the front end take commands while the slot
// engine is still sweeping.
// ----------------------------------------------------------------------------
module pwts_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pwts_pkg::entry_t  entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output pwts_pkg::entry_t  entry_o
);
  import pwts_pkg::*;

  entry_t     store_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign entry_o = store_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule : pwts_queue

@@ rtl/core/pwts_engine.sv @@
// ----------------------------------------------------------------------------
// Periodic work timer scheduler: slot engine
// Carries out queued operations on the slot table. Arm, cancel and release
// take effect as they leave the queue; iterate sweeps the slots in ascending
// order through a short pipeline and ends with a summary beat.
// ----------------------------------------------------------------------------
module pwts_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  pwts_pkg::entry_t  q_entry_i,
  output logic              q_pop_o,
  output logic              res_valid_o,
  output logic              kind_o,
  output logic [3:0]        fired_slot_o,
  output logic [31:0]       next_due_o,
  output logic              none_pending_o,
  output logic              last_o
);
  import pwts_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_SUMMARY
  } state_e;

  // Slot table: flags in flip-flops, times in memories.
  logic        armed_q [SLOTS];
  logic        held_q  [SLOTS];
  logic [31:0] period_mem [SLOTS];
  logic [31:0] due_mem    [SLOTS];

  state_e        state_q;
  logic [31:0]   now_q;
  logic [IW-1:0] idx_q;
  logic          issue_q;
  logic          s1_vld_q;
  logic          s1_last_q;
  logic [IW-1:0] s1_idx_q;
  logic [31:0]   pr_q;
  logic [31:0]   du_q;
  logic          s2_vld_q;
  logic          s2_last_q;
  logic          c_vld_q;
  logic [31:0]   c_due_q;
  logic          found_q;
  logic [31:0]   minv_q;

  logic          idle_take;
  logic          cmd_arm;
  logic          cmd_cancel;
  logic          cmd_release;
  logic          cmd_iterate;
  logic [IW-1:0] q_idx;
  logic          s1_armed;
  logic          s1_held;
  logic          s1_carry;
  logic [31:0]   s1_nxt;
  logic          s1_fire;
  logic          s1_wrap;
  logic          cand_vld;
  logic [31:0]   cand_due;
  logic          due_we;
  logic [IW-1:0] due_addr;
  logic [31:0]   due_wdata;
  logic          take_min;

  // Decode of the operation at the head of the queue.
  assign idle_take   = (state_q == ST_IDLE) & q_valid_i;
  assign q_pop_o     = idle_take;
  assign q_idx       = IW'(q_entry_i.slot);
  assign cmd_arm     = idle_take & (q_entry_i.op == OP_ARM);
  assign cmd_cancel  = idle_take & (q_entry_i.op == OP_CANCEL);
  assign cmd_release = idle_take & (q_entry_i.op == OP_RELEASE);
  assign cmd_iterate = idle_take & (q_entry_i.op == OP_ITERATE);

  // First sweep stage: test the slot and work out its next due time.
  assign s1_armed             = armed_q[s1_idx_q];
  assign s1_held              = held_q[s1_idx_q];
  assign {s1_carry, s1_nxt}   = {1'b0, now_q} + {1'b0, pr_q};
  assign s1_fire              = s1_vld_q & s1_armed & ~s1_held & (now_q >= du_q);
  // The new due time is not after the present time when the sum wraps or
  // the period is zero.
  assign s1_wrap              = s1_carry | (pr_q == 32'd0);
  assign cand_vld             = s1_armed & ~s1_held & ~(s1_fire & s1_wrap);
  assign cand_due             = s1_fire ? s1_nxt : du_q;

  // Second sweep stage: running minimum over the active slots.
  assign take_min = s2_vld_q & c_vld_q & (~found_q | (c_due_q < minv_q));

  // Due time write port, shared by arming and rescheduling.
  assign due_we    = cmd_arm | s1_fire;
  assign due_addr  = s1_fire ? s1_idx_q : q_idx;
  assign due_wdata = s1_fire ? s1_nxt : 32'd0;

  always_ff @(posedge clk_i) begin
    if (due_we) begin
      due_mem[due_addr] <= due_wdata;
    end
    if (cmd_arm) begin
      period_mem[q_idx] <= q_entry_i.value;
    end
    if (issue_q) begin
      pr_q <= period_mem[idx_q];
      du_q <= due_mem[idx_q];
    end
  end

  // Armed and held flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        armed_q[i] <= 1'b0;
        held_q[i]  <= 1'b0;
      end
    end else begin
      if (cmd_arm) begin
        armed_q[q_idx] <= 1'b1;
        held_q[q_idx]  <= 1'b0;
      end
      if (cmd_cancel) begin
        armed_q[q_idx] <= 1'b0;
      end
      if (cmd_release) begin
        for (int i = 0; i < SLOTS; i++) begin
          held_q[i] <= 1'b0;
        end
      end
      if (s1_fire) begin
        held_q[s1_idx_q] <= s1_wrap;
      end
    end
  end

  // Sequencer, sweep pipeline and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      now_q          <= '0;
      idx_q          <= '0;
      issue_q        <= 1'b0;
      s1_vld_q       <= 1'b0;
      s1_last_q      <= 1'b0;
      s1_idx_q       <= '0;
      s2_vld_q       <= 1'b0;
      s2_last_q      <= 1'b0;
      c_vld_q        <= 1'b0;
      c_due_q        <= '0;
      found_q        <= 1'b0;
      minv_q         <= '0;
      res_valid_o    <= 1'b0;
      kind_o         <= KIND_FIRED;
      fired_slot_o   <= '0;
      next_due_o     <= '0;
      none_pending_o <= 1'b0;
      last_o         <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;

      // Read issue, one slot a cycle.
      s1_vld_q  <= issue_q;
      s1_idx_q  <= idx_q;
      s1_last_q <= issue_q & (idx_q == LastIdx);
      if (issue_q) begin
        if (idx_q == LastIdx) begin
          issue_q <= 1'b0;
        end else begin
          idx_q <= idx_q + IW'(1);
        end
      end

      // Hand the candidate on to the minimum stage.
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_vld_q & s1_last_q;
      c_vld_q   <= cand_vld;
      c_due_q   <= cand_due;
      if (take_min) begin
        minv_q  <= c_due_q;
        found_q <= 1'b1;
      end

      // A fired slot gives a beat straight away.
      if (s1_fire) begin
        res_valid_o    <= 1'b1;
        kind_o         <= KIND_FIRED;
        fired_slot_o   <= 4'(s1_idx_q);
        next_due_o     <= 32'd0;
        none_pending_o <= 1'b0;
        last_o         <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (cmd_iterate) begin
            state_q <= ST_SWEEP;
            now_q   <= q_entry_i.value;
            idx_q   <= '0;
            issue_q <= 1'b1;
            found_q <= 1'b0;
            minv_q  <= '0;
          end
        end
        ST_SWEEP: begin
          if (s2_vld_q && s2_last_q) begin
            state_q <= ST_SUMMARY;
          end
        end
        ST_SUMMARY: begin
          res_valid_o    <= 1'b1;
          kind_o         <= KIND_SUMMARY;
          fired_slot_o   <= 4'd0;
          next_due_o     <= found_q ? minv_q : 32'd0;
          none_pending_o <= ~found_q;
          last_o         <= 1'b1;
          state_q        <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule : pwts_engine

@@ rtl/core/periodic_work_timer_scheduler.sv @@
// ----------------------------------------------------------------------------
// Periodic work timer scheduler: top level
// Table of periodic work slots with post, cancel, iterate and time-wrapped
// commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken at a rising edge with start high and busy low. It is
//   checked and placed in a two-entry queue; busy rises only when that queue
//   is full. Unknown codes and slot indexes not below SLOTS are dropped.
//   Post, post delayed, cancel and time wrapped finish in the slot engine
//   as they leave the queue and give no beat.
//   Iterate sweeps the slots in ascending order, one slot a cycle, and
//   gives one beat per fired slot followed by a summary beat with last set.
//   While an iterate runs, the engine takes nothing else from the queue: it
//   reads the time memories slot by slot, tests each slot in the first
//   sweep stage, keeps the running minimum in the second and ends in a
//   summary state. Fired beats are registered from the first sweep stage.
//   Each beat is shown for one cycle with res_valid_o high; the receiver
//   cannot stall it, so no back-pressure path exists.
//   Reset clears the armed and held flags, the queue and the outputs; the
//   period and due time memories are written when a slot is armed.
// ----------------------------------------------------------------------------
module periodic_work_timer_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] delay_i,
  input  logic [31:0] current_time_i,
  output logic        res_valid_o,
  output logic        kind_o,
  output logic [3:0]  fired_slot_o,
  output logic [31:0] next_due_o,
  output logic        none_pending_o,
  output logic        last_o
);
  import pwts_pkg::*;

  logic   q_full;
  logic   q_push;
  entry_t q_in;
  logic   q_valid;
  logic   q_pop;
  entry_t q_out;

  // Command check and classification.
  pwts_front u_front (
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .slot_i         (slot_i),
    .delay_i        (delay_i),
    .current_time_i (current_time_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (q_in)
  );

  // Queue between front end and slot engine.
  pwts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  // Slot table and sweep.
  pwts_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_entry_i      (q_out),
    .q_pop_o        (q_pop),
    .res_valid_o    (res_valid_o),
    .kind_o         (kind_o),
    .fired_slot_o   (fired_slot_o),
    .next_due_o     (next_due_o),
    .none_pending_o (none_pending_o),
    .last_o         (last_o)
  );

endmodule : periodic_work_timer_scheduler
